@@ design/rgb2yuv_pkg.sv @@
`default_nettype none
package rgb2yuv_pkg;

  // Configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;
  localparam int CfgSizeW = 13;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth       = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgLumaRowStride    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLumaPixelStride  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgChromaRowStride  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgChromaPixStride  = 3'd5;

  localparam int StrideW    = 15;
  localparam int PixStrideW = 3;
  localparam int CPixStrW   = 4;

  localparam logic [CfgSizeW-1:0]   RstFrameWidth      = 13'd640;
  localparam logic [CfgSizeW-1:0]   RstFrameHeight     = 13'd480;
  localparam logic [StrideW-1:0]    RstLumaRowStride   = 15'd640;
  localparam logic [PixStrideW-1:0] RstLumaPixStride   = 3'd1;
  localparam logic [StrideW-1:0]    RstChromaRowStride = 15'd640;
  localparam logic [CPixStrW-1:0]   ChromaPairStride   = 4'd2;

  // Pixel and sum widths
  localparam int PixW  = 8;
  localparam int SumW  = 9;
  localparam int LineW = 2 * SumW;
  localparam int AccW  = 17;

  // BT.601 video-range coefficients
  localparam int CoefYR  = 66;
  localparam int CoefYG  = 129;
  localparam int CoefYB  = 25;
  localparam int CoefUR  = 38;
  localparam int CoefUG  = 74;
  localparam int CoefUB  = 112;
  localparam int CoefVR  = 112;
  localparam int CoefVG  = 94;
  localparam int CoefVB  = 18;
  localparam int RoundC  = 128;
  localparam int BiasC   = 32768;
  localparam int LumaOff = 16;

endpackage
`default_nettype wire

@@ design/rgb2yuv_ifs.sv @@
`default_nettype none
interface rgb2yuv_pix_if;
  logic                          valid;
  logic                          ready;
  logic [rgb2yuv_pkg::PixW-1:0]  red;
  logic [rgb2yuv_pkg::PixW-1:0]  green;
  logic [rgb2yuv_pkg::PixW-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgb2yuv_out_if #(
  parameter int OFFSET_BITS = 28
);
  logic                          valid;
  logic                          ready;
  logic [rgb2yuv_pkg::PixW-1:0]  luma;
  logic [OFFSET_BITS-1:0]        luma_offset;
  logic                          chroma_valid;
  logic [rgb2yuv_pkg::PixW-1:0]  chroma_u;
  logic [rgb2yuv_pkg::PixW-1:0]  chroma_v;
  logic [OFFSET_BITS-1:0]        chroma_offset;
  logic                          frame_end;

  modport source (output valid, output luma, output luma_offset, output chroma_valid,
                  output chroma_u, output chroma_v, output chroma_offset,
                  output frame_end, input ready);
  modport sink   (input valid, input luma, input luma_offset, input chroma_valid,
                  input chroma_u, input chroma_v, input chroma_offset,
                  input frame_end, output ready);
endinterface
`default_nettype wire

@@ design/rgb_to_semiplanar_yuv420.sv @@
// An accepted item is registered into stage 1 and then into the output register.
// Throughput: one item per cycle unless the output stalls; the chroma line store takes
// one read and one write each cycle, the item ahead's write forwarded to the next read.
// Items taken while the chroma pixel stride is not two are dropped without a result.
// Reset (rst_ni low, asynchronous) clears counters, pair sums, valids and restores
// the register defaults; the line store is not cleared.
`default_nettype none
module rgb_to_semiplanar_yuv420 #(
  parameter int MAX_WIDTH   = 4096,
  parameter int MAX_HEIGHT  = 4096,
  parameter int OFFSET_BITS = 28
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rgb2yuv_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [rgb2yuv_pkg::CfgDataW-1:0]    cfg_data_i,
  rgb2yuv_pix_if.sink                              pix_i,
  rgb2yuv_out_if.source                            yuv_o
);

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW    = ($clog2(MAX_WIDTH + 1) > rgb2yuv_pkg::CfgSizeW) ?
                         $clog2(MAX_WIDTH + 1) : rgb2yuv_pkg::CfgSizeW;
  localparam int HW    = ($clog2(MAX_HEIGHT + 1) > rgb2yuv_pkg::CfgSizeW) ?
                         $clog2(MAX_HEIGHT + 1) : rgb2yuv_pkg::CfgSizeW;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int IW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int PW    = (RW + rgb2yuv_pkg::StrideW + 1 > OFFSET_BITS) ?
                         RW + rgb2yuv_pkg::StrideW + 1 : OFFSET_BITS;
  localparam int PXW   = rgb2yuv_pkg::PixW;
  localparam int SW    = rgb2yuv_pkg::SumW;
  localparam int AW    = rgb2yuv_pkg::AccW;

  typedef struct packed {
    logic [PXW-1:0]         lum;
    logic [PXW-1:0]         u;
    logic [PXW-1:0]         v;
    logic [OFFSET_BITS-1:0] luma_off;
    logic [OFFSET_BITS-1:0] chroma_off;
    logic                   x_odd;
    logic                   y_odd;
    logic                   last_col;
    logic                   last_row;
    logic [IW-1:0]          idx;
  } stage_t;

  // Configuration registers
  logic [rgb2yuv_pkg::CfgSizeW-1:0]   frame_width_q, frame_height_q;
  logic [rgb2yuv_pkg::StrideW-1:0]    luma_row_stride_q, chroma_row_stride_q;
  logic [rgb2yuv_pkg::PixStrideW-1:0] luma_pix_stride_q;
  logic [rgb2yuv_pkg::CPixStrW-1:0]   chroma_pix_stride_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q       <= rgb2yuv_pkg::RstFrameWidth;
      frame_height_q      <= rgb2yuv_pkg::RstFrameHeight;
      luma_row_stride_q   <= rgb2yuv_pkg::RstLumaRowStride;
      luma_pix_stride_q   <= rgb2yuv_pkg::RstLumaPixStride;
      chroma_row_stride_q <= rgb2yuv_pkg::RstChromaRowStride;
      chroma_pix_stride_q <= rgb2yuv_pkg::ChromaPairStride;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rgb2yuv_pkg::CfgFrameWidth:      frame_width_q  <= cfg_data_i[rgb2yuv_pkg::CfgSizeW-1:0];
        rgb2yuv_pkg::CfgFrameHeight:     frame_height_q <= cfg_data_i[rgb2yuv_pkg::CfgSizeW-1:0];
        rgb2yuv_pkg::CfgLumaRowStride:   luma_row_stride_q <= cfg_data_i;
        rgb2yuv_pkg::CfgLumaPixelStride:
          luma_pix_stride_q <= cfg_data_i[rgb2yuv_pkg::PixStrideW-1:0];
        rgb2yuv_pkg::CfgChromaRowStride: chroma_row_stride_q <= cfg_data_i;
        rgb2yuv_pkg::CfgChromaPixStride:
          chroma_pix_stride_q <= cfg_data_i[rgb2yuv_pkg::CPixStrW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  logic   s1_valid_q, out_valid_q;
  logic   out_free, s1_adv, accept, take;
  stage_t s1_d, s1_q;

  assign out_free    = !out_valid_q || yuv_o.ready;
  assign s1_adv      = s1_valid_q && out_free;
  assign pix_i.ready = !s1_valid_q || out_free;
  assign accept      = pix_i.valid && pix_i.ready;
  assign take        = accept && (chroma_pix_stride_q == rgb2yuv_pkg::ChromaPairStride);

  // Stage 0: position, colour transform, offsets
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic [WW-1:0] w_sat;
  logic [HW-1:0] h_sat;
  logic          last_col, last_row;
  logic [CW-1:0] idx_full;
  logic [IW-1:0] rd_idx;
  logic [AW-1:0] y_sum, u_sum, v_sum;
  logic [SW-1:0] lum_tmp;
  logic [PW-1:0] luma_off_w, chroma_off_w;

  always_comb begin
    w_sat = WW'(frame_width_q);
    if (frame_width_q == '0) w_sat = WW'(1);
    else if (WW'(frame_width_q) > WW'(MAX_WIDTH)) w_sat = WW'(MAX_WIDTH);
    h_sat = HW'(frame_height_q);
    if (frame_height_q == '0) h_sat = HW'(1);
    else if (HW'(frame_height_q) > HW'(MAX_HEIGHT)) h_sat = HW'(MAX_HEIGHT);
  end

  assign last_col = WW'(col_q) >= (w_sat - WW'(1));
  assign last_row = HW'(row_q) >= (h_sat - HW'(1));

  assign idx_full = col_q >> 1;
  assign rd_idx   = (idx_full >= CW'(LINE_DEPTH)) ? IW'(LINE_DEPTH - 1) : idx_full[IW-1:0];

  assign y_sum = AW'(rgb2yuv_pkg::CoefYR) * AW'(pix_i.red)
               + AW'(rgb2yuv_pkg::CoefYG) * AW'(pix_i.green)
               + AW'(rgb2yuv_pkg::CoefYB) * AW'(pix_i.blue)
               + AW'(rgb2yuv_pkg::RoundC);
  // the bias keeps both sums positive, so the top bits give floor((t+128)/256) + 128
  assign u_sum = AW'(rgb2yuv_pkg::CoefUB) * AW'(pix_i.blue)
               + AW'(rgb2yuv_pkg::RoundC + rgb2yuv_pkg::BiasC)
               - AW'(rgb2yuv_pkg::CoefUR) * AW'(pix_i.red)
               - AW'(rgb2yuv_pkg::CoefUG) * AW'(pix_i.green);
  assign v_sum = AW'(rgb2yuv_pkg::CoefVR) * AW'(pix_i.red)
               + AW'(rgb2yuv_pkg::RoundC + rgb2yuv_pkg::BiasC)
               - AW'(rgb2yuv_pkg::CoefVG) * AW'(pix_i.green)
               - AW'(rgb2yuv_pkg::CoefVB) * AW'(pix_i.blue);
  assign lum_tmp = y_sum[AW-1:8] + SW'(rgb2yuv_pkg::LumaOff);

  assign luma_off_w   = PW'(row_q) * PW'(luma_row_stride_q)
                      + PW'(col_q) * PW'(luma_pix_stride_q);
  assign chroma_off_w = PW'(row_q >> 1) * PW'(chroma_row_stride_q)
                      + (PW'(col_q >> 1) << 1);

  always_comb begin
    s1_d.lum        = lum_tmp[SW-1] ? {PXW{1'b1}} : lum_tmp[PXW-1:0];
    s1_d.u          = u_sum[15:8];
    s1_d.v          = v_sum[15:8];
    s1_d.luma_off   = luma_off_w[OFFSET_BITS-1:0];
    s1_d.chroma_off = chroma_off_w[OFFSET_BITS-1:0];
    s1_d.x_odd      = col_q[0];
    s1_d.y_odd      = row_q[0];
    s1_d.last_col   = last_col;
    s1_d.last_row   = last_row;
    s1_d.idx        = rd_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Stage 1: pair sums, line store read-modify-write, averaging
  logic [SW-1:0]    pair_u_q, pair_v_q, pair_u_d, pair_v_d;
  logic [2*SW-1:0]  line_mem [LINE_DEPTH];
  logic [2*SW-1:0]  rd_q, fwd_q, line_data, wr_data;
  logic             fwd_hit_q;
  logic             close, store, emit, wr_en;
  logic [SW:0]      su, sv, su_div, sv_div;
  logic [PXW-1:0]   cu, cv;

  always_comb begin
    pair_u_d  = s1_q.x_odd ? pair_u_q + SW'(s1_q.u) : SW'(s1_q.u);
    pair_v_d  = s1_q.x_odd ? pair_v_q + SW'(s1_q.v) : SW'(s1_q.v);
    close     = s1_q.x_odd || s1_q.last_col;
    store     = close && !s1_q.y_odd && !s1_q.last_row;
    emit      = close && !store;
    line_data = fwd_hit_q ? fwd_q : rd_q;
    su        = (SW+1)'(pair_u_d);
    sv        = (SW+1)'(pair_v_d);
    if (s1_q.y_odd) begin
      su = su + (SW+1)'(line_data[2*SW-1:SW]);
      sv = sv + (SW+1)'(line_data[SW-1:0]);
    end
    if (s1_q.x_odd && s1_q.y_odd) begin
      su_div = su >> 2;
      sv_div = sv >> 2;
    end else if (s1_q.x_odd ^ s1_q.y_odd) begin
      su_div = su >> 1;
      sv_div = sv >> 1;
    end else begin
      su_div = su;
      sv_div = sv;
    end
    cu      = (|su_div[SW:PXW]) ? {PXW{1'b1}} : su_div[PXW-1:0];
    cv      = (|sv_div[SW:PXW]) ? {PXW{1'b1}} : sv_div[PXW-1:0];
    wr_en   = s1_adv && store;
    wr_data = {pair_u_d, pair_v_d};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[s1_q.idx] <= wr_data;
    end
    if (take) begin
      rd_q  <= line_mem[rd_idx];
      fwd_q <= wr_data;
      s1_q  <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
      pair_u_q   <= '0;
      pair_v_q   <= '0;
    end else begin
      if (pix_i.ready) begin
        s1_valid_q <= take;
      end
      if (take) begin
        // the write of the item leaving stage 1 misses the memory read this cycle
        fwd_hit_q <= wr_en && (s1_q.idx == rd_idx);
      end
      if (s1_adv) begin
        pair_u_q <= pair_u_d;
        pair_v_q <= pair_v_d;
      end
    end
  end

  // Output register
  logic [PXW-1:0]         luma_q, cu_q, cv_q;
  logic [OFFSET_BITS-1:0] luma_off_q, chroma_off_q;
  logic                   chroma_valid_q, frame_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      luma_q         <= s1_q.lum;
      luma_off_q     <= s1_q.luma_off;
      chroma_valid_q <= emit;
      cu_q           <= emit ? cu : '0;
      cv_q           <= emit ? cv : '0;
      chroma_off_q   <= emit ? s1_q.chroma_off : '0;
      frame_end_q    <= s1_q.last_col && s1_q.last_row;
    end
  end

  assign yuv_o.valid         = out_valid_q;
  assign yuv_o.luma          = luma_q;
  assign yuv_o.luma_offset   = luma_off_q;
  assign yuv_o.chroma_valid  = chroma_valid_q;
  assign yuv_o.chroma_u      = cu_q;
  assign yuv_o.chroma_v      = cv_q;
  assign yuv_o.chroma_offset = chroma_off_q;
  assign yuv_o.frame_end     = frame_end_q;

endmodule
`default_nettype wire

@@ design/rgb2yuv_checker.sv @@
`default_nettype none
module rgb2yuv_checker #(
  parameter int OFFSET_BITS = 28
) (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               out_valid_i,
  input wire logic                               out_ready_i,
  input wire logic                               chroma_valid_i,
  input wire logic [rgb2yuv_pkg::PixW-1:0]       chroma_u_i,
  input wire logic [rgb2yuv_pkg::PixW-1:0]       chroma_v_i,
  input wire logic [OFFSET_BITS-1:0]             chroma_offset_i,
  input wire logic                               frame_end_i
);

  // nothing leaves while reset is held
  a_no_valid_in_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !chroma_valid_i |->
      chroma_u_i == '0 && chroma_v_i == '0 && chroma_offset_i == '0)
    else $error("chroma fields not cleared without a completed block");

  // the last pixel of a frame always closes a block
  a_frame_end_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_end_i |-> chroma_valid_i)
    else $error("frame end without chroma");

endmodule

bind rgb_to_semiplanar_yuv420 rgb2yuv_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_rgb2yuv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (yuv_o.valid),
  .out_ready_i     (yuv_o.ready),
  .chroma_valid_i  (yuv_o.chroma_valid),
  .chroma_u_i      (yuv_o.chroma_u),
  .chroma_v_i      (yuv_o.chroma_v),
  .chroma_offset_i (yuv_o.chroma_offset),
  .frame_end_i     (yuv_o.frame_end)
);
`default_nettype wire

@@ verif/rgb_to_semiplanar_yuv420_checker.sv @@
`timescale 1ns / 1ps
module rgb_to_semiplanar_yuv420_checker
  import rgb2yuv_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  rgb2yuv_pix_if              pix_i,
  rgb2yuv_out_if              yuv_i,
  output int                  mismatches_o,
  output int                  words_due_o
);

  localparam int MaxWidth    = 4096;
  localparam int MaxHeight   = 4096;
  localparam int OffW        = 28;
  localparam int LineDepth   = 2048;

  typedef struct packed {
    logic [PixW-1:0] luma;
    logic [OffW-1:0] luma_off;
    logic            cvalid;
    logic [PixW-1:0] u;
    logic [PixW-1:0] v;
    logic [OffW-1:0] coff;
    logic            fend;
  } nv12_word_t;

  nv12_word_t nv12_due[$];

  logic [CfgSizeW-1:0]   frame_w_q, frame_h_q;
  logic [StrideW-1:0]    luma_rs_q, chroma_rs_q;
  logic [PixStrideW-1:0] luma_ps_q;
  logic [CPixStrW-1:0]   chroma_ps_q;

  logic [11:0]      col_q, row_q;
  logic [SumW-1:0]  u_pair_q, v_pair_q;
  logic [LineW-1:0] chroma_line [0:LineDepth-1];

  int mismatch_count = 0;
  int due_count      = 0;

  assign mismatches_o = mismatch_count;
  assign words_due_o  = due_count;

  function automatic logic [7:0] clamp_byte(input int v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  function automatic int sat_dim(input logic [CfgSizeW-1:0] v, input int top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return int'(v);
  endfunction

  task automatic flag(input string what, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  // Work out the luma byte for this pixel and, on the closing pixel of a
  // 2x2 block, the averaged chroma pair.
  task automatic convert_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int         ri, gi, bi, w_eff, h_eff, u_pix, v_pix, u_acc, v_acc, samples;
    logic       last_col, last_row;
    logic [10:0] slot;
    longint     lin, chr;
    nv12_word_t word;
    // drop the item when the pair stride is off
    if (chroma_ps_q != ChromaPairStride) return;
    ri = int'(r);
    gi = int'(g);
    bi = int'(b);
    w_eff = sat_dim(frame_w_q, MaxWidth);
    h_eff = sat_dim(frame_h_q, MaxHeight);
    last_col = int'(col_q) >= w_eff - 1;
    last_row = int'(row_q) >= h_eff - 1;
    word = '0;
    word.luma = clamp_byte(((66 * ri + 129 * gi + 25 * bi + 128) >>> 8) + 16);
    // bias keeps the sums positive so the shift floors
    u_pix = (112 * bi + 128 + 32768 - 38 * ri - 74 * gi) >>> 8;
    v_pix = (112 * ri + 128 + 32768 - 94 * gi - 18 * bi) >>> 8;
    if (!col_q[0]) begin
      u_pair_q = u_pix[SumW-1:0];
      v_pair_q = v_pix[SumW-1:0];
    end else begin
      u_pair_q = u_pair_q + u_pix[SumW-1:0];
      v_pair_q = v_pair_q + v_pix[SumW-1:0];
    end
    slot = col_q[11:1];
    if (col_q[0] || last_col) begin
      samples = col_q[0] ? 2 : 1;
      u_acc = int'(u_pair_q);
      v_acc = int'(v_pair_q);
      if (!row_q[0] && !last_row) begin
        chroma_line[slot] = {u_pair_q, v_pair_q};
      end else begin
        if (row_q[0]) begin
          u_acc += int'(chroma_line[slot][LineW-1:SumW]);
          v_acc += int'(chroma_line[slot][SumW-1:0]);
          samples *= 2;
        end
        chr = longint'(row_q[11:1]) * longint'(chroma_rs_q) + longint'(slot) * 2;
        word.cvalid = 1'b1;
        word.u = clamp_byte(u_acc / samples);
        word.v = clamp_byte(v_acc / samples);
        word.coff = chr[OffW-1:0];
      end
    end
    lin = longint'(row_q) * longint'(luma_rs_q) + longint'(col_q) * longint'(luma_ps_q);
    word.luma_off = lin[OffW-1:0];
    word.fend = last_col && last_row;
    if (last_col) begin
      col_q = '0;
      row_q = last_row ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
    nv12_due.push_back(word);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    nv12_word_t want;
    if (!rst_ni) begin
      frame_w_q   = RstFrameWidth;
      frame_h_q   = RstFrameHeight;
      luma_rs_q   = RstLumaRowStride;
      luma_ps_q   = RstLumaPixStride;
      chroma_rs_q = RstChromaRowStride;
      chroma_ps_q = ChromaPairStride;
      col_q       = '0;
      row_q       = '0;
      u_pair_q    = '0;
      v_pair_q    = '0;
      nv12_due.delete();
    end else begin
      // compare first so a result on the accepting edge is caught
      if (yuv_i.valid && yuv_i.ready) begin
        if (nv12_due.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual luma 0x%0h offset 0x%0h",
                   $time, yuv_i.luma, yuv_i.luma_offset);
        end else begin
          want = nv12_due.pop_front();
          flag("luma", want.luma, yuv_i.luma);
          flag("luma_offset", want.luma_off, yuv_i.luma_offset);
          flag("chroma_valid", want.cvalid, yuv_i.chroma_valid);
          flag("chroma_u", want.u, yuv_i.chroma_u);
          flag("chroma_v", want.v, yuv_i.chroma_v);
          flag("chroma_offset", want.coff, yuv_i.chroma_offset);
          flag("frame_end", want.fend, yuv_i.frame_end);
        end
      end
      if (pix_i.valid && pix_i.ready)
        convert_pixel(pix_i.red, pix_i.green, pix_i.blue);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgFrameWidth:      frame_w_q   = cfg_data_i[CfgSizeW-1:0];
          CfgFrameHeight:     frame_h_q   = cfg_data_i[CfgSizeW-1:0];
          CfgLumaRowStride:   luma_rs_q   = cfg_data_i[StrideW-1:0];
          CfgLumaPixelStride: luma_ps_q   = cfg_data_i[PixStrideW-1:0];
          CfgChromaRowStride: chroma_rs_q = cfg_data_i[StrideW-1:0];
          CfgChromaPixStride: chroma_ps_q = cfg_data_i[CPixStrW-1:0];
          default: ;
        endcase
      end
    end
    due_count = nv12_due.size();
  end

endmodule

@@ verif/rgb_to_semiplanar_yuv420_tb.sv @@
`timescale 1ns / 1ps
module rgb_to_semiplanar_yuv420_tb;
  import rgb2yuv_pkg::*;

  localparam int StallLimit = 2000;
  localparam int MaxDim     = 4096;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  logic [CfgSizeW-1:0]   frame_w, frame_h;
  logic [StrideW-1:0]    luma_rs, chroma_rs;
  logic [PixStrideW-1:0] luma_ps;
  logic [CPixStrW-1:0]   chroma_ps;

  int send_idle_pct  = 15;
  int recv_stall_pct = 71;
  int quiet_cycles   = 0;
  int mismatches;
  int words_due;

  rgb2yuv_pix_if pix ();
  rgb2yuv_out_if #(.OFFSET_BITS(28)) yuv ();

  rgb_to_semiplanar_yuv420 uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix),
    .yuv_o      (yuv)
  );

  rgb_to_semiplanar_yuv420_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pix_i        (pix),
    .yuv_i        (yuv),
    .mismatches_o (mismatches),
    .words_due_o  (words_due)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    yuv.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      yuv.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (yuv.valid && yuv.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= StallLimit);
    $display("rgb_to_semiplanar_yuv420 verification failed");
    $finish;
  end

  function automatic int frame_pixels();
    int w, h;
    w = (frame_w == '0) ? 1 : (int'(frame_w) > MaxDim) ? MaxDim : int'(frame_w);
    h = (frame_h == '0) ? 1 : (int'(frame_h) > MaxDim) ? MaxDim : int'(frame_h);
    return w * h;
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [StrideW-1:0] rand_stride();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return StrideW'($urandom);
    endcase
  endfunction

  // Write all six registers back to back; spare data bits carry noise.
  task automatic write_registers();
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: begin
          cfg_idx  <= CfgFrameWidth;
          cfg_data <= {2'($urandom), frame_w};
        end
        1: begin
          cfg_idx  <= CfgFrameHeight;
          cfg_data <= {2'($urandom), frame_h};
        end
        2: begin
          cfg_idx  <= CfgLumaRowStride;
          cfg_data <= luma_rs;
        end
        3: begin
          cfg_idx  <= CfgLumaPixelStride;
          cfg_data <= {12'($urandom), luma_ps};
        end
        4: begin
          cfg_idx  <= CfgChromaRowStride;
          cfg_data <= chroma_rs;
        end
        default: begin
          cfg_idx  <= CfgChromaPixStride;
          cfg_data <= {11'($urandom), chroma_ps};
        end
      endcase
      cfg_we <= 1'b1;
      @(negedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every result, then cover the pipeline latency.
  task automatic drain();
    pix.valid <= 1'b0;
    while (words_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.red   <= r;
    pix.green <= g;
    pix.blue  <= b;
    do @(posedge clk_i); while (!pix.ready);
    @(negedge clk_i);
  endtask

  task automatic send_random_pixel();
    send_pixel(rand_level(), rand_level(), rand_level());
  endtask

  // Switch the pair stride off for a few items, which must vanish.
  task automatic drop_burst();
    drain();
    chroma_ps = 4'($urandom_range(0, 14));
    if (chroma_ps >= ChromaPairStride) chroma_ps++;
    write_registers();
    repeat ($urandom_range(1, 4)) send_random_pixel();
    drain();
    chroma_ps = ChromaPairStride;
    write_registers();
  endtask

  task automatic send_frame(input bit noisy);
    int total;
    total = frame_pixels();
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 59) == 0) drop_burst();
      send_random_pixel();
    end
  endtask

  task automatic pick_frame();
    case ($urandom_range(0, 9))
      0: frame_w = '0;
      1: frame_w = CfgSizeW'($urandom_range(10, 24));
      default: frame_w = CfgSizeW'($urandom_range(1, 9));
    endcase
    frame_h   = ($urandom_range(0, 9) == 0) ? '0 : CfgSizeW'($urandom_range(1, 7));
    luma_rs   = rand_stride();
    chroma_rs = rand_stride();
    luma_ps   = PixStrideW'($urandom);
    chroma_ps = ChromaPairStride;
  endtask

  task automatic run_frames(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      drain();
      pick_frame();
      write_registers();
      send_frame(1'b1);
      sent += frame_pixels();
    end
  endtask

  initial begin
    pix.valid = 1'b0;
    pix.red   = '0;
    pix.green = '0;
    pix.blue  = '0;
    cfg_we    = 1'b0;
    cfg_idx   = CfgFrameWidth;
    cfg_data  = '0;
    rst_ni    = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // 3x3 frame: single, pair and quad chroma blocks with pure colours
    frame_w   = 13'd3;
    frame_h   = 13'd3;
    luma_rs   = '1;
    luma_ps   = '1;
    chroma_rs = '1;
    chroma_ps = ChromaPairStride;
    write_registers();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'hFF, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h80, 8'h80, 8'h80);
    drain();

    // shrink the frame part way through; items with the stride off vanish
    frame_w   = 13'd6;
    frame_h   = 13'd6;
    luma_rs   = 15'd6;
    luma_ps   = 3'd1;
    chroma_rs = 15'd6;
    write_registers();
    repeat (9) send_random_pixel();
    drain();
    frame_w   = 13'd2;
    chroma_ps = 4'd0;
    write_registers();
    repeat (2) send_random_pixel();
    drain();
    chroma_ps = ChromaPairStride;
    write_registers();
    repeat (3) send_random_pixel();
    drain();
    frame_h = 13'd3;
    write_registers();
    repeat (2) send_random_pixel();
    drain();

    // zero sizes saturate to one pixel per frame
    frame_w   = '0;
    frame_h   = '0;
    luma_rs   = '0;
    luma_ps   = '0;
    chroma_rs = '0;
    write_registers();
    repeat (2) send_random_pixel();
    run_frames(230);

    send_idle_pct  = 71;
    recv_stall_pct = 15;
    run_frames(230);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // oversized sizes saturate; shrink to 2x2 part way through the first row
    drain();
    frame_w   = '1;
    frame_h   = '1;
    luma_rs   = rand_stride();
    luma_ps   = '1;
    chroma_rs = rand_stride();
    write_registers();
    repeat (60) send_random_pixel();
    drain();
    frame_w = 13'd2;
    frame_h = 13'd2;
    write_registers();
    repeat (3) send_random_pixel();
    run_frames(200);

    drain();
    repeat (6) @(negedge clk_i);
    if (mismatches == 0 && words_due == 0) begin
      $display("rgb_to_semiplanar_yuv420 verification clean");
    end else begin
      $display("rgb_to_semiplanar_yuv420 verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rgb2yuv_pkg.sv
design/rgb2yuv_ifs.sv
design/rgb_to_semiplanar_yuv420.sv
design/rgb2yuv_checker.sv
verif/rgb_to_semiplanar_yuv420_checker.sv
verif/rgb_to_semiplanar_yuv420_tb.sv
